// ----- rtl/hough_pose_bin_generator_macros.svh -----
// ----------------------------------------------------------------------------
// Hough pose bin generator assertion macros
// Concurrent assertion helpers shared by the RTL of the bin generator.
// ----------------------------------------------------------------------------
`ifndef HOUGH_POSE_BIN_GENERATOR_MACROS_SVH
`define HOUGH_POSE_BIN_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define HPB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define HPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/hpb_pkg.sv -----
// ----------------------------------------------------------------------------
// Hough pose bin generator package
// Stage record types, configuration indexes and the location bin helper.
// ----------------------------------------------------------------------------
package hpb_pkg;

    localparam int QBITS   = 19;   // quotient bits kept at the lower scale
    localparam int NUMW    = 46;   // dividend width
    localparam int DENW    = 39;   // divisor width
    localparam int CMPW    = DENW + QBITS + 1;

    localparam logic [1:0] CFG_ORIENT_RECIP = 2'd0;
    localparam logic [1:0] CFG_MAX_ORIENT   = 2'd1;
    localparam logic [1:0] CFG_LOC_STEP     = 2'd2;

    typedef struct packed {
        logic [31:0] prod;
        logic [4:0]  lead;
        logic [23:0] mant;
        logic [15:0] ext;
        logic [15:0] cx;
        logic [15:0] cy;
    } st1_t;

    typedef struct packed {
        logic [7:0]  ob0;
        logic [7:0]  ob1;
        logic [4:0]  lead;
        logic        up;
        logic [31:0] dd;
        logic [15:0] cx;
        logic [15:0] cy;
    } st2_t;

    typedef struct packed {
        logic [7:0]             ob0;
        logic [7:0]             ob1;
        logic signed [5:0]      sb0;
        logic                   up;
        logic                   negx;
        logic                   negy;
        logic                   ovfx;
        logic                   ovfy;
        logic [DENW-1:0]        den;
        logic [NUMW-1:0]        remx;
        logic [NUMW-1:0]        remy;
        logic [QBITS-1:0]       qx;
        logic [QBITS-1:0]       qy;
    } div_t;

    typedef struct packed {
        logic signed [15:0] b0;
        logic signed [15:0] b1;
        logic               s0;
        logic               s1;
    } bins_t;

    function automatic logic [16:0] clamp16(input logic signed [20:0] v);
        logic [16:0] r;
        if (v > 21'sd32767) begin
            r = {1'b1, 16'h7FFF};
        end else if (v < -21'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

    // Floor bin and nearer neighbour from the unsigned quotient at the lower
    // scale; the upper scale halves that quotient.
    function automatic bins_t loc_bins(input logic [QBITS-1:0] u_lo, input logic exact_lo,
                                       input logic neg, input logic ovf, input logic hi);
        logic [QBITS-1:0]   u;
        logic               ex;
        logic signed [20:0] q;
        logic signed [20:0] b0;
        logic signed [20:0] b1;
        logic [16:0]        c0;
        logic [16:0]        c1;
        bins_t              r;
        u  = hi ? (u_lo >> 1) : u_lo;
        ex = hi ? (exact_lo & ~u_lo[0]) : exact_lo;
        q  = {2'b00, u};
        if (neg) begin
            q = -(q + {20'd0, ~ex});
        end
        b0 = q >>> 1;
        b1 = q[0] ? (b0 + 21'sd1) : (b0 - 21'sd1);
        if (ovf) begin
            b0 = neg ? -21'sd262144 : 21'sd262144;
            b1 = b0;
        end
        c0 = clamp16(b0);
        c1 = clamp16(b1);
        r.b0 = c0[15:0];
        r.s0 = c0[16];
        r.b1 = c1[15:0];
        r.s1 = c1[16];
        return r;
    endfunction

endpackage

// ----- rtl/hough_pose_bin_generator.sv -----
// ----------------------------------------------------------------------------
// Hough pose bin generator
// Turns one feature match into sixteen pose bins for Hough voting.
// ----------------------------------------------------------------------------
// Each accepted match word yields sixteen bin words, one per cycle while m_tready
// is high, in the order scale, orientation, y, x with the floor bin first in
// each dimension. A match runs through a 22-stage pipeline: input products and
// leading-one search, bin selection, operand alignment, then a 19-stage
// restoring divider that computes the x and y location quotients side by side.
// The sixteen output words hold the sustained rate to one match per sixteen
// words; the next match is taken while the current bins are still being sent.

module hough_pose_bin_generator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // orientation[15:0], scale[39:16], box_width[55:40], box_height[71:56],
    // center_x[87:72], center_y[103:88]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // orient_bin[7:0], scale_bin[13:8], x_bin[29:14], y_bin[45:30], zero[47:46]
    output logic [47:0]  m_tdata,
    // saturated[0]
    output logic [0:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    localparam int NDIV = hpb_pkg::QBITS;

    logic [15:0] recip_reg;
    logic [7:0]  max_ob_reg;
    logic [15:0] loc_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_reg    <= 16'd7823;
            max_ob_reg   <= 8'd11;
            loc_step_reg <= 16'd1024;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                hpb_pkg::CFG_ORIENT_RECIP: recip_reg    <= cfg_wdata;
                hpb_pkg::CFG_MAX_ORIENT:   max_ob_reg   <= cfg_wdata[7:0];
                hpb_pkg::CFG_LOC_STEP:     loc_step_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic load;
    logic beat;

    // Stage 1: orientation product, leading one, normalized mantissa.
    hpb_pkg::st1_t st1_reg, st1_next;
    logic          v1_reg;

    always_comb begin
        logic [23:0] sc;
        logic [4:0]  ld;
        logic [15:0] w;
        logic [15:0] h;
        sc = s_tdata[39:16];
        w  = s_tdata[55:40];
        h  = s_tdata[71:56];
        ld = 5'd0;
        for (int i = 1; i < 24; i++) begin
            if (sc[i]) begin
                ld = 5'(i);
            end
        end
        if (sc == 24'd0) begin
            sc = 24'd1;
        end
        st1_next.prod = 32'(s_tdata[15:0]) * 32'(recip_reg);
        st1_next.lead = ld;
        st1_next.mant = sc << (5'd23 - ld);
        st1_next.ext  = (w > h) ? w : h;
        if (st1_next.ext == 16'd0) begin
            st1_next.ext = 16'd1;
        end
        st1_next.cx = s_tdata[87:72];
        st1_next.cy = s_tdata[103:88];
    end

    // Stage 2: orientation bins, sqrt 2 test, location extent product.
    hpb_pkg::st2_t st2_reg, st2_next;
    logic          v2_reg;

    always_comb begin
        logic [47:0] sq;
        logic [15:0] ls;
        logic [7:0]  b;
        sq = 48'(st1_reg.mant) * 48'(st1_reg.mant);
        ls = (loc_step_reg == 16'd0) ? 16'd1 : loc_step_reg;
        b  = {1'b0, st1_reg.prod[31:25]};
        st2_next.ob0 = b;
        if (!st1_reg.prod[24]) begin
            st2_next.ob1 = (b == 8'd0) ? max_ob_reg : (b - 8'd1);
        end else begin
            st2_next.ob1 = (b == max_ob_reg) ? 8'd0 : (b + 8'd1);
        end
        st2_next.lead = st1_reg.lead;
        st2_next.up   = sq[47] && (sq[46:0] != 47'd0);
        st2_next.dd   = 32'(st1_reg.ext) * 32'(ls);
        st2_next.cx   = st1_reg.cx;
        st2_next.cy   = st1_reg.cy;
    end

    // Stage 3: align the operands at the lower of the two scale bins.
    hpb_pkg::div_t div_reg [0:NDIV];
    logic          dv_reg  [0:NDIV];
    hpb_pkg::div_t div0_next;
    hpb_pkg::div_t div_next [1:NDIV];

    always_comb begin
        logic signed [5:0]  sb0;
        logic signed [5:0]  smin;
        logic [2:0]         shd;
        logic [4:0]         shm;
        logic [15:0]        ax;
        logic [15:0]        ay;
        logic [hpb_pkg::CMPW-1:0] lim;
        sb0  = 6'(st2_reg.lead) - 6'sd16;
        smin = st2_reg.up ? sb0 : (sb0 - 6'sd1);
        shd  = (smin > 6'sd0) ? smin[2:0] : 3'd0;
        shm  = (smin < 6'sd0) ? 5'(-smin) : 5'd0;
        ax   = st2_reg.cx[15] ? (~st2_reg.cx + 16'd1) : st2_reg.cx;
        ay   = st2_reg.cy[15] ? (~st2_reg.cy + 16'd1) : st2_reg.cy;
        div0_next.ob0  = st2_reg.ob0;
        div0_next.ob1  = st2_reg.ob1;
        div0_next.sb0  = sb0;
        div0_next.up   = st2_reg.up;
        div0_next.negx = st2_reg.cx[15];
        div0_next.negy = st2_reg.cy[15];
        div0_next.den  = hpb_pkg::DENW'(st2_reg.dd) << shd;
        div0_next.remx = hpb_pkg::NUMW'({ax, 13'd0}) << shm;
        div0_next.remy = hpb_pkg::NUMW'({ay, 13'd0}) << shm;
        div0_next.qx   = '0;
        div0_next.qy   = '0;
        lim = hpb_pkg::CMPW'(div0_next.den) << NDIV;
        div0_next.ovfx = hpb_pkg::CMPW'(div0_next.remx) >= lim;
        div0_next.ovfy = hpb_pkg::CMPW'(div0_next.remy) >= lim;
    end

    // Divider stages: one quotient bit per stage for both lanes.
    always_comb begin
        logic [hpb_pkg::CMPW-1:0] sd;
        for (int k = 0; k < NDIV; k++) begin
            div_next[k+1] = div_reg[k];
            sd = hpb_pkg::CMPW'(div_reg[k].den) << (NDIV - 1 - k);
            if (hpb_pkg::CMPW'(div_reg[k].remx) >= sd) begin
                div_next[k+1].remx = div_reg[k].remx - hpb_pkg::NUMW'(sd);
                div_next[k+1].qx[NDIV-1-k] = 1'b1;
            end
            if (hpb_pkg::CMPW'(div_reg[k].remy) >= sd) begin
                div_next[k+1].remy = div_reg[k].remy - hpb_pkg::NUMW'(sd);
                div_next[k+1].qy[NDIV-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k <= NDIV; k++) begin
                dv_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int k = 0; k < NDIV; k++) begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_reg    <= st1_next;
            st2_reg    <= st2_next;
            div_reg[0] <= div0_next;
            for (int k = 1; k <= NDIV; k++) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // Output holding stage: the sixteen bins of one match.
    logic [7:0]         ob_reg   [0:1];
    logic signed [5:0]  sb_reg   [0:1];
    hpb_pkg::bins_t     xb_reg   [0:1];
    hpb_pkg::bins_t     yb_reg   [0:1];
    logic               hold_valid_reg;
    logic [3:0]         cnt_reg;

    hpb_pkg::div_t fin;
    hpb_pkg::bins_t xb_next [0:1];
    hpb_pkg::bins_t yb_next [0:1];

    assign fin = div_reg[NDIV];

    always_comb begin
        logic ex_x;
        logic ex_y;
        ex_x = fin.remx == '0;
        ex_y = fin.remy == '0;
        // The first scale bin sits on the upper quotient when the neighbour
        // lies below it.
        xb_next[0] = hpb_pkg::loc_bins(fin.qx, ex_x, fin.negx, fin.ovfx, ~fin.up);
        xb_next[1] = hpb_pkg::loc_bins(fin.qx, ex_x, fin.negx, fin.ovfx, fin.up);
        yb_next[0] = hpb_pkg::loc_bins(fin.qy, ex_y, fin.negy, fin.ovfy, ~fin.up);
        yb_next[1] = hpb_pkg::loc_bins(fin.qy, ex_y, fin.negy, fin.ovfy, fin.up);
    end

    assign beat = m_tvalid && m_tready;
    assign load = dv_reg[NDIV] && (!hold_valid_reg || (beat && cnt_reg == 4'd15));
    assign en   = !dv_reg[NDIV] || load;
    assign s_tready = en && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            cnt_reg        <= 4'd0;
        end else if (load) begin
            hold_valid_reg <= 1'b1;
            cnt_reg        <= 4'd0;
        end else if (beat) begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ob_reg[0] <= fin.ob0;
            ob_reg[1] <= fin.ob1;
            sb_reg[0] <= fin.sb0;
            sb_reg[1] <= fin.up ? (fin.sb0 + 6'sd1) : (fin.sb0 - 6'sd1);
            xb_reg    <= xb_next;
            yb_reg    <= yb_next;
        end
    end

    always_comb begin
        hpb_pkg::bins_t xs;
        hpb_pkg::bins_t ys;
        logic [15:0]    xv;
        logic [15:0]    yv;
        logic           sat;
        xs  = xb_reg[cnt_reg[3]];
        ys  = yb_reg[cnt_reg[3]];
        xv  = cnt_reg[0] ? xs.b1 : xs.b0;
        yv  = cnt_reg[1] ? ys.b1 : ys.b0;
        sat = (cnt_reg[0] ? xs.s1 : xs.s0) | (cnt_reg[1] ? ys.s1 : ys.s0);
        m_tdata = {2'b00, yv, xv, sb_reg[cnt_reg[3]], ob_reg[cnt_reg[2]]};
        m_tuser = sat;
    end

    assign m_tvalid = hold_valid_reg;
    assign m_tlast  = cnt_reg == 4'd15;

`include "hough_pose_bin_generator_macros.svh"

    `HPB_ASSERT_SAME(a_stall_src, aclk, aresetn, !s_tready, dv_reg[NDIV] && hold_valid_reg)
    `HPB_ASSERT_NEXT(a_cnt_step, aclk, aresetn, beat && !m_tlast, m_tvalid && cnt_reg == $past(cnt_reg) + 4'd1)
    `HPB_ASSERT_NEXT(a_load_first, aclk, aresetn, load, m_tvalid && cnt_reg == 4'd0)

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Hough pose bin generator testbench
// Sends feature matches through the stream input, predicts the sixteen pose
// bins of each match and checks every output word in order. Covers directed
// edge cases, several register settings and random matches with random
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic [15:0]        orient;
        logic [23:0]        scale;
        logic [15:0]        w;
        logic [15:0]        h;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
    } match_t;

    typedef struct {
        logic [7:0]         orient_bin;
        logic signed [5:0]  scale_bin;
        logic signed [15:0] x_bin;
        logic signed [15:0] y_bin;
        logic               sat;
        logic               last;
    } pose_bin_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_wr_en;
    logic [1:0]   cfg_addr;
    logic [15:0]  cfg_wdata;

    // Predictor copy of the registers.
    logic [15:0] orient_recip;
    logic [7:0]  max_orient;
    logic [15:0] loc_step;

    pose_bin_t pending_bins[$];
    int        mismatches;
    int        idle_cycles;
    bit        no_idle;

    hough_pose_bin_generator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // floor(2 * c * 4096 / (d * 2^s)), exact in 64 bits.
    function automatic longint loc_quot(longint c, longint unsigned d, int s);
        longint unsigned mag;
        longint unsigned q;
        mag = longint'(c < 0 ? -c : c) << 13;
        if (s >= 0) d = d << s;
        else mag = mag << (-s);
        q = mag / d;
        if (c >= 0) return longint'(q);
        if (q * d != mag) q = q + 1;
        return -longint'(q);
    endfunction

    function automatic longint clamp_bin(longint v, ref logic sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic void predict_bins(match_t m);
        longint unsigned p, sc, d, fext, fstep;
        logic [7:0]      ob[2];
        int              sb[2];
        int              lead;
        longint          qx, qy, xb[2], yb[2], xv, yv;
        logic            sat;
        pose_bin_t       r;
        int              n;
        p = longint'(m.orient) * longint'(orient_recip);
        ob[0] = 8'((p >> 25) & 255);
        if ((p & ((64'd1 << 25) - 1)) < (64'd1 << 24))
            ob[1] = (ob[0] == 0) ? max_orient : ob[0] - 8'd1;
        else
            ob[1] = (ob[0] == max_orient) ? 8'd0 : ob[0] + 8'd1;
        sc = (m.scale == 0) ? 1 : m.scale;
        lead = 0;
        while (lead < 23 && (sc >> (lead + 1)) != 0) lead++;
        sb[0] = lead - 16;
        sb[1] = (sc * sc > (64'd1 << (2 * lead + 1))) ? sb[0] + 1 : sb[0] - 1;
        fext = (m.w > m.h) ? m.w : m.h;
        if (fext == 0) fext = 1;
        fstep = (loc_step == 0) ? 1 : loc_step;
        d = fext * fstep;
        n = 0;
        for (int si = 0; si < 2; si++) begin
            qx = loc_quot(m.cx, d, sb[si]);
            qy = loc_quot(m.cy, d, sb[si]);
            xb[0] = (qx - (qx & 1)) / 2;
            xb[1] = xb[0] + ((qx & 1) ? 1 : -1);
            yb[0] = (qy - (qy & 1)) / 2;
            yb[1] = yb[0] + ((qy & 1) ? 1 : -1);
            for (int oi = 0; oi < 2; oi++)
                for (int yi = 0; yi < 2; yi++)
                    for (int xi = 0; xi < 2; xi++) begin
                        sat = 1'b0;
                        xv = clamp_bin(xb[xi], sat);
                        yv = clamp_bin(yb[yi], sat);
                        r.orient_bin = ob[oi];
                        r.scale_bin  = 6'(sb[si]);
                        r.x_bin      = 16'(xv);
                        r.y_bin      = 16'(yv);
                        r.sat        = sat;
                        r.last       = (n == 15);
                        pending_bins.insert(pending_bins.size(), r);
                        n++;
                    end
        end
    endfunction

    // Output checker: one word per handshake, compared with the oldest bin.
    always @(posedge aclk) begin
        pose_bin_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bins.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", m_tdata);
            end else begin
                e = pending_bins.pop_front();
                if (m_tdata[7:0] !== e.orient_bin || m_tdata[13:8] !== e.scale_bin ||
                    m_tdata[29:14] !== e.x_bin || m_tdata[45:30] !== e.y_bin ||
                    m_tdata[47:46] !== 2'b00 || m_tuser[0] !== e.sat ||
                    m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("bin mismatch: exp o=%0d s=%0d x=%0d y=%0d sat=%b last=%b",
                                 e.orient_bin, e.scale_bin, e.x_bin, e.y_bin, e.sat,
                                 e.last);
                        $display("              got o=%0d s=%0d x=%0d y=%0d sat=%b last=%b z=%b",
                                 m_tdata[7:0], $signed(m_tdata[13:8]),
                                 $signed(m_tdata[29:14]), $signed(m_tdata[45:30]),
                                 m_tuser[0], m_tlast, m_tdata[47:46]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= no_idle || ($urandom_range(0, 99) >= 15);
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("[hough_pose_bin_generator] ERROR");
            $finish;
        end
    end

    task automatic send_match(match_t m);
        if (!no_idle && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {m.cy, m.cx, m.h, m.w, m.scale, m.orient};
        do @(posedge aclk); while (!s_tready);
        predict_bins(m);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            hpb_pkg::CFG_ORIENT_RECIP: orient_recip = val;
            hpb_pkg::CFG_MAX_ORIENT:   max_orient = val[7:0];
            hpb_pkg::CFG_LOC_STEP:     loc_step = val;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(logic [15:0] recip, logic [15:0] maxb, logic [15:0] step);
        drain();
        write_reg(hpb_pkg::CFG_ORIENT_RECIP, recip);
        write_reg(hpb_pkg::CFG_MAX_ORIENT, maxb);
        write_reg(hpb_pkg::CFG_LOC_STEP, step);
    endtask

    function automatic match_t mk(logic [15:0] o, logic [23:0] s, logic [15:0] w,
                                  logic [15:0] h, logic [15:0] cx, logic [15:0] cy);
        match_t m;
        m.orient = o; m.scale = s; m.w = w; m.h = h; m.cx = cx; m.cy = cy;
        return m;
    endfunction

    // Values spread over all magnitudes so every leading-one position occurs.
    function automatic logic [23:0] rand_mag(int bits);
        return 24'($urandom & ((32'd1 << $urandom_range(1, bits)) - 1));
    endfunction

    function automatic match_t rand_match();
        return mk($urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 51471)),
                  rand_mag(24), 16'(rand_mag(16)), 16'(rand_mag(16)),
                  $urandom_range(0, 1) ? 16'($urandom) : 16'(rand_mag(10)) ^
                      {16{$urandom_range(0, 1) == 1}},
                  $urandom_range(0, 1) ? 16'($urandom) : 16'(rand_mag(10)) ^
                      {16{$urandom_range(0, 1) == 1}});
    endfunction

    task automatic test_directed();
        send_match(mk(16'd0, 24'h010000, 16'h0100, 16'h0100, 16'sd0, 16'sd0));
        send_match(mk(16'd51471, 24'h010000, 16'h0100, 16'h0080, 16'sd100, -16'sd100));
        send_match(mk(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000));
        // Zero scale and zero box extent.
        send_match(mk(16'd4000, 24'd0, 16'd0, 16'd0, 16'h7FFF, 16'h8000));
        send_match(mk(16'd1, 24'd1, 16'd1, 16'd1, -16'sd1, 16'sd1));
        // Mantissa just below and just above sqrt 2.
        send_match(mk(16'd2000, 24'h016A09, 16'h0200, 16'h0300, 16'sd777, -16'sd555));
        send_match(mk(16'd2000, 24'h016A0A, 16'h0200, 16'h0300, 16'sd777, -16'sd555));
        // Orientation near the half fraction and near the wrap bins.
        send_match(mk(16'd2144, 24'h020000, 16'h0040, 16'h0040, 16'sd64, 16'sd63));
        send_match(mk(16'd2145, 24'h020000, 16'h0040, 16'h0040, -16'sd64, -16'sd63));
        send_match(mk(16'd50000, 24'h008000, 16'h0010, 16'h0020, 16'sd32, -16'sd32));
        send_match(mk(16'd100, 24'h800000, 16'h0010, 16'h0010, 16'sd16, 16'sd17));
        // Saturating location bins.
        send_match(mk(16'd300, 24'h000001, 16'd1, 16'd2, 16'h7FFF, -16'sd32768));
        send_match(mk(16'd300, 24'h000003, 16'd1, 16'd0, -16'sd5, 16'sd5));
    endtask

    task automatic test_reg_settings();
        match_t m;
        set_regs(16'hFFFF, 16'd255, 16'd1);
        for (int i = 0; i < 8; i++) send_match(rand_match());
        set_regs(16'd1, 16'd0, 16'hFFFF);
        for (int i = 0; i < 8; i++) send_match(rand_match());
        // Zero step is treated as one; an unused index is ignored.
        set_regs(16'd8192, 16'd3, 16'd0);
        drain();
        write_reg(CFG_UNUSED, 16'hFFFF);
        for (int i = 0; i < 8; i++) send_match(rand_match());
        // Orientation bins above the last bin are left unwrapped.
        set_regs(16'd40000, 16'd2, 16'd1024);
        m = mk(16'd51471, 24'h010000, 16'h0100, 16'h0100, 16'sd10, 16'sd10);
        send_match(m);
        for (int i = 0; i < 6; i++) send_match(rand_match());
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) set_regs(16'd7823, 16'd11, 16'd1024);
            else set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 255)),
                          16'($urandom_range(1, 65535)));
            no_idle = (ph == 2);
            for (int i = 0; i < 60; i++) send_match(rand_match());
            no_idle = 1'b0;
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        no_idle     = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        orient_recip = 16'd7823;
        max_orient   = 8'd11;
        loc_step     = 16'd1024;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_reg_settings();
        test_random();
        drain();
        if (mismatches == 0 && pending_bins.size() == 0) begin
            $display("[hough_pose_bin_generator] OK");
        end else begin
            $display("[hough_pose_bin_generator] ERROR");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hpb_pkg.sv
rtl/hough_pose_bin_generator.sv
sim/tb.sv
